// ----- design/rau_pkg.sv -----
// ============================================================================
// Rational arithmetic unit package
// Shared widths, operation codes, payload structs and unit handshake types.
// ============================================================================
`default_nettype none

package rau_pkg;

   // Word width of integer work; sums and products wrap at this width, but compares use double-width products.
   localparam int WORD_BITS = 32;
   localparam int FUNC_BITS = 4;
   localparam int DEN_BITS  = 31;
   localparam int DWORD_BITS = 2 * WORD_BITS;

   // Depth of the queue between the front and the back.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   // Step counter of the divider and shift count of the GCD unit.
   localparam int STEP_BITS = $clog2(WORD_BITS);

   // Operation codes.
   localparam logic [FUNC_BITS-1:0] FN_MAKE = 4'd0;
   localparam logic [FUNC_BITS-1:0] FN_ADD  = 4'd1;
   localparam logic [FUNC_BITS-1:0] FN_SUB  = 4'd2;
   localparam logic [FUNC_BITS-1:0] FN_MUL  = 4'd3;
   localparam logic [FUNC_BITS-1:0] FN_DIV  = 4'd4;
   localparam logic [FUNC_BITS-1:0] FN_LT   = 4'd5;
   localparam logic [FUNC_BITS-1:0] FN_GT   = 4'd6;
   localparam logic [FUNC_BITS-1:0] FN_LE   = 4'd7;
   localparam logic [FUNC_BITS-1:0] FN_GE   = 4'd8;

   typedef logic signed [WORD_BITS-1:0]  word_type;
   typedef logic signed [DWORD_BITS-1:0] dword_type;
   typedef logic [WORD_BITS-1:0]         uword_type;

   typedef struct packed {
      logic [FUNC_BITS-1:0] func;
      word_type             a_num;
      word_type             a_den;
      word_type             b_num;
      logic [DEN_BITS-1:0]  b_den;
   } req_type;

   typedef struct packed {
      word_type            res_num;
      logic [DEN_BITS-1:0] res_den;
      logic                cmp_true;
   } rsp_type;

   // Operation class assigned by the front.
   typedef enum logic [2:0] {
      CLS_MAKE,
      CLS_ADDSUB,
      CLS_MULDIV,
      CLS_CMP,
      CLS_NONE
   } cls_type;

   typedef struct packed {
      cls_type cls;
      req_type req;
   } job_type;

   typedef struct packed {
      logic     start;
      word_type dividend;
      word_type divisor;
   } div_req_type;

   typedef struct packed {
      logic     start;
      word_type x_val;
      word_type y_val;
   } gcd_req_type;

   typedef struct packed {
      logic     done;
      word_type value;
   } unit_rsp_type;

   // Sequencer states of the back.
   typedef enum logic [4:0] {
      ST_IDLE,
      ST_LOAD_B,
      ST_DISPATCH,
      ST_NORM_PREP,
      ST_NORM_GCD,
      ST_NORM_GCD_WAIT,
      ST_NORM_DIVN,
      ST_NORM_DIVN_WAIT,
      ST_NORM_DIVD,
      ST_NORM_DIVD_WAIT,
      ST_MD_NUM,
      ST_MD_DEN,
      ST_MD_SAVE,
      ST_AS_MUL,
      ST_AS_GCD,
      ST_AS_GCD_WAIT,
      ST_AS_LCM,
      ST_AS_LCM_WAIT,
      ST_AS_XMUL,
      ST_AS_XDIV,
      ST_AS_XDIV_WAIT,
      ST_AS_YMUL,
      ST_AS_YDIV,
      ST_AS_YDIV_WAIT,
      ST_CMP_LHS,
      ST_CMP_RHS,
      ST_CMP_DONE,
      ST_RESULT
   } back_state_type;

   // Magnitude of a word as an unsigned word; the most negative word maps
   // to its true magnitude.
   function automatic uword_type magnitude(word_type v);
      uword_type u;
      u = uword_type'(v);
      return u[WORD_BITS-1] ? (~u + 1'b1) : u;
   endfunction

endpackage

`default_nettype wire

// ----- design/rau_front.sv -----
// ============================================================================
// Rational arithmetic unit front
// Accepts items, classifies the operation and queues them for the back.
// ============================================================================
`default_nettype none

module rau_front (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   output logic            busy,
   input  rau_pkg::req_type req_data,
   output logic            job_valid,
   output rau_pkg::job_type job,
   input  logic            job_pop
);
   import rau_pkg::*;

   job_type               q_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0]  count_ff, count_in;
   logic                  push;
   logic                  pop_ok;
   cls_type               cls;

   // Classify the operation code.
   always_comb begin
      case (req_data.func)
         FN_MAKE:                      cls = CLS_MAKE;
         FN_ADD, FN_SUB:               cls = CLS_ADDSUB;
         FN_MUL, FN_DIV:               cls = CLS_MULDIV;
         FN_LT, FN_GT, FN_LE, FN_GE:   cls = CLS_CMP;
         default:                      cls = CLS_NONE;
      endcase
   end

   // Handshake and queue pointers.
   assign busy      = (count_ff == QCNT_BITS'(QUEUE_DEPTH));
   assign push      = start && !busy;
   assign job_valid = (count_ff != '0);
   assign pop_ok    = job_pop && job_valid;
   assign job       = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_ok) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop_ok) begin
         count_in = count_ff + 1'b1;
      end else if (!push && pop_ok) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage.
   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= '{cls: cls, req: req_data};
      end
   end

`ifndef SYNTHESIS
   // A push without a pop adds exactly one entry.
   a_count_up: assert property (@(posedge clock) disable iff (reset)
      push && !pop_ok |=> count_ff == QCNT_BITS'($past(count_ff) + 1'b1))
      else $error("queue count did not grow on push");
`endif

endmodule

`default_nettype wire

// ----- design/rau_gcd.sv -----
// ============================================================================
// Rational arithmetic unit GCD engine
// Binary GCD on operand magnitudes, one subtract-or-shift step per cycle.
// ============================================================================
`default_nettype none

module rau_gcd (
   input  logic                  clock,
   input  logic                  reset,
   input  rau_pkg::gcd_req_type  gcd_req,
   output rau_pkg::unit_rsp_type gcd_rsp
);
   import rau_pkg::*;

   logic                 run_ff, run_in;
   logic                 done_ff, done_in;
   uword_type            u_ff, u_in;
   uword_type            v_ff, v_in;
   logic [STEP_BITS-1:0] k_ff, k_in;
   uword_type            g_ff, g_in;

   // One Stein step; finishes when either value reaches zero.
   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      u_in    = u_ff;
      v_in    = v_ff;
      k_in    = k_ff;
      g_in    = g_ff;
      if (gcd_req.start) begin
         run_in = 1'b1;
         u_in   = magnitude(gcd_req.x_val);
         v_in   = magnitude(gcd_req.y_val);
         k_in   = '0;
      end else if (run_ff) begin
         if (u_ff == '0 || v_ff == '0) begin
            run_in  = 1'b0;
            done_in = 1'b1;
            g_in    = (u_ff | v_ff) << k_ff;
         end else if (!u_ff[0] && !v_ff[0]) begin
            u_in = u_ff >> 1;
            v_in = v_ff >> 1;
            k_in = k_ff + 1'b1;
         end else if (!u_ff[0]) begin
            u_in = u_ff >> 1;
         end else if (!v_ff[0]) begin
            v_in = v_ff >> 1;
         end else if (u_ff >= v_ff) begin
            u_in = (u_ff - v_ff) >> 1;
         end else begin
            v_in = (v_ff - u_ff) >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      u_ff <= u_in;
      v_ff <= v_in;
      k_ff <= k_in;
      g_ff <= g_in;
   end

   assign gcd_rsp.done  = done_ff;
   assign gcd_rsp.value = word_type'(g_ff);

endmodule

`default_nettype wire

// ----- design/rau_div.sv -----
// ============================================================================
// Rational arithmetic unit divider
// Signed truncating division, one restoring quotient bit per cycle.
// ============================================================================
`default_nettype none

module rau_div (
   input  logic                  clock,
   input  logic                  reset,
   input  rau_pkg::div_req_type  div_req,
   output rau_pkg::unit_rsp_type div_rsp
);
   import rau_pkg::*;

   logic                 run_ff, run_in;
   logic                 done_ff, done_in;
   logic [STEP_BITS-1:0] cnt_ff, cnt_in;
   uword_type            rem_ff, rem_in;
   uword_type            quo_ff, quo_in;
   uword_type            dvs_ff, dvs_in;
   logic                 neg_ff, neg_in;
   uword_type            quot_ff, quot_in;
   logic [WORD_BITS:0]   rem_sh;
   logic                 fits;
   uword_type            rem_nx;
   uword_type            quo_nx;

   // Restoring step on magnitudes. The partial remainder stays below the
   // divisor, so it always fits in one word.
   assign rem_sh = {rem_ff, quo_ff[WORD_BITS-1]};
   assign fits   = (rem_sh >= {1'b0, dvs_ff});
   assign rem_nx = fits ? uword_type'(rem_sh - {1'b0, dvs_ff}) : rem_sh[WORD_BITS-1:0];
   assign quo_nx = {quo_ff[WORD_BITS-2:0], fits};

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      neg_in  = neg_ff;
      quot_in = quot_ff;
      if (div_req.start) begin
         run_in = 1'b1;
         cnt_in = '0;
         rem_in = '0;
         quo_in = magnitude(div_req.dividend);
         dvs_in = magnitude(div_req.divisor);
         neg_in = div_req.dividend[WORD_BITS-1] ^ div_req.divisor[WORD_BITS-1];
      end else if (run_ff) begin
         rem_in = rem_nx;
         quo_in = quo_nx;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == STEP_BITS'(WORD_BITS - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
            quot_in = neg_ff ? (~quo_nx + 1'b1) : quo_nx;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff  <= cnt_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      dvs_ff  <= dvs_in;
      neg_ff  <= neg_in;
      quot_ff <= quot_in;
   end

   assign div_rsp.done  = done_ff;
   assign div_rsp.value = word_type'(quot_ff);

`ifndef SYNTHESIS
   // The sequencer never restarts a division that is still running.
   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> !run_ff)
      else $error("divider started while busy");
`endif

endmodule

`default_nettype wire

// ----- design/rau_back.sv -----
// ============================================================================
// Rational arithmetic unit back
// Sequencer that normalizes operands and carries out each operation with a
// shared multiplier, the GCD engine and the divider.
// ============================================================================
`default_nettype none

module rau_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  job_valid,
   input  rau_pkg::job_type      job,
   output logic                  job_pop,
   output rau_pkg::gcd_req_type  gcd_req,
   input  rau_pkg::unit_rsp_type gcd_rsp,
   output rau_pkg::div_req_type  div_req,
   input  rau_pkg::unit_rsp_type div_rsp,
   output logic                  rsp_strobe,
   output rau_pkg::rsp_type      rsp_data
);
   import rau_pkg::*;

   back_state_type       state_ff, state_in;
   back_state_type       ret_ff, ret_in;
   cls_type              cls_ff, cls_in;
   logic [FUNC_BITS-1:0] func_ff, func_in;
   word_type             an_ff, an_in, ad_ff, ad_in;
   word_type             bn_ff, bn_in, bd_ff, bd_in;
   word_type             nn_ff, nn_in, nd_ff, nd_in;
   word_type             tmp_ff, tmp_in;
   word_type             l_ff, l_in;
   word_type             g_ff, g_in;
   dword_type            prod_ff, prod_in;
   dword_type            lhs_ff, lhs_in;
   word_type             mul_x, mul_y;
   logic                 rsp_strobe_ff, rsp_strobe_in;
   rsp_type              rsp_ff, rsp_in;
   logic                 lt_raw, gt_raw, lt_fix, gt_fix;
   logic                 cmp_bit;

   // Shared multiplier, registered every cycle.
   assign prod_in = dword_type'(mul_x) * dword_type'(mul_y);

   // Exact compare; a negative a denominator flips the order.
   assign lt_raw = (lhs_ff < prod_ff);
   assign gt_raw = (lhs_ff > prod_ff);
   assign lt_fix = ad_ff[WORD_BITS-1] ? gt_raw : lt_raw;
   assign gt_fix = ad_ff[WORD_BITS-1] ? lt_raw : gt_raw;

   always_comb begin
      case (func_ff)
         FN_LT:   cmp_bit = lt_fix;
         FN_GT:   cmp_bit = gt_fix;
         FN_LE:   cmp_bit = !gt_fix;
         default: cmp_bit = !lt_fix;
      endcase
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:           if (job_valid) state_in = ST_NORM_PREP;
         ST_LOAD_B:         state_in = ST_NORM_PREP;
         ST_DISPATCH: begin
            case (cls_ff)
               CLS_ADDSUB: state_in = ST_AS_MUL;
               CLS_MULDIV: state_in = ST_MD_NUM;
               CLS_CMP:    state_in = ST_CMP_LHS;
               default:    state_in = ST_RESULT;
            endcase
         end
         ST_NORM_PREP:      state_in = ST_NORM_GCD;
         ST_NORM_GCD:       state_in = ST_NORM_GCD_WAIT;
         ST_NORM_GCD_WAIT:  if (gcd_rsp.done) state_in = ST_NORM_DIVN;
         ST_NORM_DIVN:      state_in = ST_NORM_DIVN_WAIT;
         ST_NORM_DIVN_WAIT: if (div_rsp.done) state_in = ST_NORM_DIVD;
         ST_NORM_DIVD:      state_in = ST_NORM_DIVD_WAIT;
         ST_NORM_DIVD_WAIT: if (div_rsp.done) state_in = ret_ff;
         ST_MD_NUM:         state_in = ST_MD_DEN;
         ST_MD_DEN:         state_in = ST_MD_SAVE;
         ST_MD_SAVE:        state_in = ST_NORM_PREP;
         ST_AS_MUL:         state_in = ST_AS_GCD;
         ST_AS_GCD:         state_in = ST_AS_GCD_WAIT;
         ST_AS_GCD_WAIT:    if (gcd_rsp.done) state_in = ST_AS_LCM;
         ST_AS_LCM:         state_in = ST_AS_LCM_WAIT;
         ST_AS_LCM_WAIT:    if (div_rsp.done) state_in = ST_AS_XMUL;
         ST_AS_XMUL:        state_in = ST_AS_XDIV;
         ST_AS_XDIV:        state_in = ST_AS_XDIV_WAIT;
         ST_AS_XDIV_WAIT:   if (div_rsp.done) state_in = ST_AS_YMUL;
         ST_AS_YMUL:        state_in = ST_AS_YDIV;
         ST_AS_YDIV:        state_in = ST_AS_YDIV_WAIT;
         ST_AS_YDIV_WAIT:   if (div_rsp.done) state_in = ST_NORM_PREP;
         ST_CMP_LHS:        state_in = ST_CMP_RHS;
         ST_CMP_RHS:        state_in = ST_CMP_DONE;
         ST_CMP_DONE:       state_in = ST_IDLE;
         ST_RESULT:         state_in = ST_IDLE;
         default:           state_in = ST_IDLE;
      endcase
   end

   // Outputs and datapath.
   always_comb begin
      job_pop       = 1'b0;
      gcd_req       = '{start: 1'b0, x_val: nn_ff, y_val: nd_ff};
      div_req       = '{start: 1'b0, dividend: nn_ff, divisor: g_ff};
      mul_x         = an_ff;
      mul_y         = bd_ff;
      ret_in        = ret_ff;
      cls_in        = cls_ff;
      func_in       = func_ff;
      an_in         = an_ff;
      ad_in         = ad_ff;
      bn_in         = bn_ff;
      bd_in         = bd_ff;
      nn_in         = nn_ff;
      nd_in         = nd_ff;
      tmp_in        = tmp_ff;
      l_in          = l_ff;
      g_in          = g_ff;
      lhs_in        = lhs_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      case (state_ff)
         ST_IDLE: begin
            if (job_valid) begin
               job_pop = 1'b1;
               cls_in  = job.cls;
               func_in = job.req.func;
               bn_in   = job.req.b_num;
               bd_in   = word_type'({1'b0, job.req.b_den});
               nn_in   = job.req.a_num;
               nd_in   = job.req.a_den;
               ret_in  = ST_LOAD_B;
            end
         end
         ST_LOAD_B: begin
            an_in  = nn_ff;
            ad_in  = nd_ff;
            nn_in  = bn_ff;
            nd_in  = bd_ff;
            ret_in = ST_DISPATCH;
         end
         ST_DISPATCH: begin
            bn_in = nn_ff;
            bd_in = nd_ff;
            if (cls_ff == CLS_MAKE) begin
               nn_in = an_ff;
               nd_in = ad_ff;
            end else begin
               nn_in = '0;
               nd_in = word_type'(1);
            end
         end
         // Zero denominator becomes one; a negative sign moves up.
         ST_NORM_PREP: begin
            if (nd_ff == '0) begin
               nd_in = word_type'(1);
            end else if (nd_ff[WORD_BITS-1]) begin
               nd_in = -nd_ff;
               nn_in = -nn_ff;
            end
         end
         ST_NORM_GCD: begin
            gcd_req.start = 1'b1;
         end
         ST_NORM_GCD_WAIT: begin
            if (gcd_rsp.done) g_in = gcd_rsp.value;
         end
         ST_NORM_DIVN: begin
            div_req.start = 1'b1;
         end
         ST_NORM_DIVN_WAIT: begin
            if (div_rsp.done) nn_in = div_rsp.value;
         end
         ST_NORM_DIVD: begin
            div_req = '{start: 1'b1, dividend: nd_ff, divisor: g_ff};
         end
         ST_NORM_DIVD_WAIT: begin
            if (div_rsp.done) nd_in = div_rsp.value;
         end
         // Multiply and divide: numerator and denominator products (crossed for divide), then normalize.
         ST_MD_NUM: begin
            mul_x = an_ff;
            mul_y = (func_ff == FN_MUL) ? bn_ff : bd_ff;
         end
         ST_MD_DEN: begin
            nn_in = prod_ff[WORD_BITS-1:0];
            mul_x = ad_ff;
            mul_y = (func_ff == FN_MUL) ? bd_ff : bn_ff;
         end
         ST_MD_SAVE: begin
            nd_in  = prod_ff[WORD_BITS-1:0];
            ret_in = ST_RESULT;
         end
         // Add and subtract over the least common denominator.
         ST_AS_MUL: begin
            mul_x = ad_ff;
            mul_y = bd_ff;
         end
         ST_AS_GCD: begin
            tmp_in  = prod_ff[WORD_BITS-1:0];
            gcd_req = '{start: 1'b1, x_val: ad_ff, y_val: bd_ff};
         end
         ST_AS_GCD_WAIT: begin
            if (gcd_rsp.done) g_in = gcd_rsp.value;
         end
         ST_AS_LCM: begin
            div_req = '{start: 1'b1, dividend: tmp_ff, divisor: g_ff};
         end
         ST_AS_LCM_WAIT: begin
            if (div_rsp.done) l_in = div_rsp.value;
         end
         ST_AS_XMUL: begin
            mul_x = an_ff;
            mul_y = l_ff;
         end
         ST_AS_XDIV: begin
            div_req = '{start: 1'b1, dividend: prod_ff[WORD_BITS-1:0], divisor: ad_ff};
         end
         ST_AS_XDIV_WAIT: begin
            if (div_rsp.done) tmp_in = div_rsp.value;
         end
         ST_AS_YMUL: begin
            mul_x = bn_ff;
            mul_y = l_ff;
         end
         ST_AS_YDIV: begin
            div_req = '{start: 1'b1, dividend: prod_ff[WORD_BITS-1:0], divisor: bd_ff};
         end
         ST_AS_YDIV_WAIT: begin
            if (div_rsp.done) begin
               nn_in  = (func_ff == FN_SUB) ? (tmp_ff - div_rsp.value)
                                            : (tmp_ff + div_rsp.value);
               nd_in  = l_ff;
               ret_in = ST_RESULT;
            end
         end
         // Compares cross-multiply at double width.
         ST_CMP_LHS: begin
            mul_x = an_ff;
            mul_y = bd_ff;
         end
         ST_CMP_RHS: begin
            lhs_in = prod_ff;
            mul_x  = bn_ff;
            mul_y  = ad_ff;
         end
         ST_CMP_DONE: begin
            rsp_strobe_in = 1'b1;
            rsp_in = '{res_num: '0, res_den: DEN_BITS'(1), cmp_true: cmp_bit};
         end
         ST_RESULT: begin
            rsp_strobe_in = 1'b1;
            rsp_in = '{res_num: nn_ff, res_den: nd_ff[DEN_BITS-1:0], cmp_true: 1'b0};
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      ret_ff  <= ret_in;
      cls_ff  <= cls_in;
      func_ff <= func_in;
      an_ff   <= an_in;
      ad_ff   <= ad_in;
      bn_ff   <= bn_in;
      bd_ff   <= bd_in;
      nn_ff   <= nn_in;
      nd_ff   <= nd_in;
      tmp_ff  <= tmp_in;
      l_ff    <= l_in;
      g_ff    <= g_in;
      prod_ff <= prod_in;
      lhs_ff  <= lhs_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

`ifndef SYNTHESIS
   // Results are never delivered in two adjacent cycles.
   a_strobe_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |=> !rsp_strobe_ff)
      else $error("back-to-back result strobes");

   // A true compare carries the neutral rational.
   a_cmp_payload: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff && rsp_ff.cmp_true |->
         rsp_ff.res_num == '0 && rsp_ff.res_den == DEN_BITS'(1))
      else $error("compare result with nonzero rational");

   // Items leave the queue only when the sequencer is idle.
   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      job_pop |-> state_ff == ST_IDLE && job_valid)
      else $error("queue popped outside idle");
`endif

endmodule

`default_nettype wire

// ----- design/rational_arith_unit.sv -----
// ============================================================================
// Rational arithmetic unit
// Reduced rational make, add, subtract, multiply, divide and exact compares.
// ============================================================================
// Usage: drive req_data and raise start; the item is taken at a rising edge
// where start is high and busy is low. busy rises only when the two-entry
// queue in front of the sequencer is full, so two items can be handed over
// back to back while an earlier one is being worked on.
// Each item gives exactly one result, shown on rsp_data for one cycle with
// rsp_strobe high. The receiver cannot hold results off, and none is needed:
// the sequencer writes the output register once per item.
// The sequencer works on one item at a time. Its time per item is set by
// the radix-2 divider (up to nine quotients for add and subtract) and by
// the binary GCD engine (one step per cycle, up to four GCDs). Make and the
// unused operation codes are the shortest, compares add the cross-multiply
// states, and add and subtract are the longest.
// Reset (synchronous, active high) empties the queue, returns the sequencer
// to idle and drops any item in flight; no result is given for it.
// ============================================================================
`default_nettype none

module rational_arith_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  rau_pkg::req_type req_data,
   output logic             rsp_strobe,
   output rau_pkg::rsp_type rsp_data
);
   import rau_pkg::*;

   logic          job_valid;
   job_type       job;
   logic          job_pop;
   gcd_req_type   gcd_req;
   unit_rsp_type  gcd_rsp;
   div_req_type   div_req;
   unit_rsp_type  div_rsp;

   // Intake and classification.
   rau_front u_front (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .job_valid (job_valid),
      .job       (job),
      .job_pop   (job_pop)
   );

   // Shared arithmetic units.
   rau_gcd u_gcd (
      .clock   (clock),
      .reset   (reset),
      .gcd_req (gcd_req),
      .gcd_rsp (gcd_rsp)
   );

   rau_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // Operation sequencer.
   rau_back u_back (
      .clock      (clock),
      .reset      (reset),
      .job_valid  (job_valid),
      .job        (job),
      .job_pop    (job_pop),
      .gcd_req    (gcd_req),
      .gcd_rsp    (gcd_rsp),
      .div_req    (div_req),
      .div_rsp    (div_rsp),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule

`default_nettype wire

// ----- tb/rational_arith_unit_test.sv -----
// ============================================================================
// Rational arithmetic unit testbench
// Drives directed and random items through the command port and compares
// every result, field by field, with a predicted reduced rational or compare.
// ============================================================================
`default_nettype none

module rational_arith_unit_test;
   import rau_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 50000;
   localparam int DRAIN_CYCLES   = 1000;
   localparam int RANDOM_ITEMS   = 1500;
   localparam logic [FUNC_BITS-1:0] FN_SPARE = FN_GE + 4'd1;

   typedef struct {
      longint n;
      longint d;
   } frac_type;

   // Predicts each result from the accepted item and holds the results due.
   class rational_scoreboard;
      rsp_type pending[$];
      int      errors;

      // Low 32 bits of a value, sign-extended, as the word arithmetic wraps.
      static function longint wrap(longint x);
         int t;
         t = x[31:0];
         return t;
      endfunction

      static function longint euclid(longint x, longint y);
         longint r;
         while (y != 0) begin
            r = x % y;
            x = y;
            y = r;
         end
         return (x > -x) ? x : wrap(-x);
      endfunction

      static function frac_type reduce(longint n, longint d);
         frac_type f;
         longint   g;
         n = wrap(n);
         d = wrap(d);
         if (d == 0) d = 1;
         if (d < 0) begin
            d = wrap(-d);
            n = wrap(-n);
         end
         g = euclid(n, d);
         f.n = wrap(n / g);
         f.d = wrap(d / g);
         return f;
      endfunction

      static function frac_type add_or_sub(frac_type a, frac_type b, bit minus);
         longint g, l, x, y;
         g = euclid(a.d, b.d);
         l = wrap(wrap(a.d * b.d) / g);
         x = wrap(wrap(a.n * l) / a.d);
         y = wrap(wrap(b.n * l) / b.d);
         return reduce(minus ? x - y : x + y, l);
      endfunction

      // Exact ordering by full-width cross products: -1, 0 or 1.
      static function int order(frac_type a, frac_type b);
         longint lhs, rhs;
         int     c;
         lhs = a.n * b.d;
         rhs = b.n * a.d;
         c = (lhs < rhs) ? -1 : ((lhs > rhs) ? 1 : 0);
         if ((a.d < 0) != (b.d < 0)) c = -c;
         return c;
      endfunction

      function void note(req_type q);
         frac_type a, b, r;
         rsp_type  e;
         int       c;
         a = reduce(longint'(q.a_num), longint'(q.a_den));
         b = reduce(longint'(q.b_num), longint'({1'b0, q.b_den}));
         r.n = 0;
         r.d = 1;
         e.cmp_true = 1'b0;
         case (q.func)
            FN_MAKE: r = a;
            FN_ADD:  r = add_or_sub(a, b, 1'b0);
            FN_SUB:  r = add_or_sub(a, b, 1'b1);
            FN_MUL:  r = reduce(a.n * b.n, a.d * b.d);
            FN_DIV:  r = reduce(a.n * b.d, a.d * b.n);
            FN_LT, FN_GT, FN_LE, FN_GE: begin
               c = order(a, b);
               case (q.func)
                  FN_LT:   e.cmp_true = (c < 0);
                  FN_GT:   e.cmp_true = (c > 0);
                  FN_LE:   e.cmp_true = (c <= 0);
                  default: e.cmp_true = (c >= 0);
               endcase
            end
            default: ;
         endcase
         e.res_num = r.n[31:0];
         e.res_den = r.d[30:0];
         pending.push_back(e);
      endfunction

      function void check(rsp_type got);
         rsp_type e;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result num=%0d den=%0d cmp=%0b", $realtime,
                     got.res_num, got.res_den, got.cmp_true);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (got.res_num !== e.res_num) begin
            $display("%0t: res_num expected %0d actual %0d", $realtime, e.res_num,
                     got.res_num);
            errors++;
         end
         if (got.res_den !== e.res_den) begin
            $display("%0t: res_den expected %0d actual %0d", $realtime, e.res_den,
                     got.res_den);
            errors++;
         end
         if (got.cmp_true !== e.cmp_true) begin
            $display("%0t: cmp_true expected %0b actual %0b", $realtime, e.cmp_true,
                     got.cmp_true);
            errors++;
         end
      endfunction
   endclass

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_strobe;
   rsp_type rsp_data;

   rational_scoreboard board;
   int  quiet_cycles;
   bit  no_gaps;

   rational_arith_unit uut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   initial clock = 1'b0;
   always #4 clock = ~clock;

   // Record accepted items and check results; the watchdog counts quiet cycles.
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) board.note(req_data);
         if (rsp_strobe) board.check(rsp_data);
         if ((start && !busy) || rsp_strobe) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
               $display("CHECK FAILED");
               $finish;
            end
         end
      end
   end

   // Mostly no gap, some short ones and a few long ones.
   function automatic int gap_length();
      int p;
      if (no_gaps) return 0;
      p = $urandom_range(0, 99);
      if (p < 55) return 0;
      if (p < 90) return $urandom_range(1, 4);
      return $urandom_range(20, 200);
   endfunction

   // Words mixing small values, extremes, shared factors and raw bit patterns.
   function automatic logic [31:0] pick_word();
      int p;
      p = $urandom_range(0, 99);
      if (p < 30) return 32'($signed($urandom_range(0, 40)) - 20);
      if (p < 40) begin
         case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h8000_0001;
            2: return 32'hFFFF_FFFF;
            3: return 32'h0;
            4: return 32'h1;
            default: return 32'h7FFF_FFFF;
         endcase
      end
      if (p < 70) return 32'($urandom_range(1, 3000) * ($urandom_range(0, 1) ? 6 : -10));
      if (p < 85) return 32'($signed($urandom_range(0, 200000)) - 100000);
      return $urandom();
   endfunction

   task automatic send(req_type q);
      int g;
      req_data <= q;
      start    <= 1'b1;
      do @(posedge clock); while (busy);
      g = gap_length();
      if (g > 0) begin
         start <= 1'b0;
         repeat (g) @(posedge clock);
      end
   endtask

   task automatic send_item(logic [FUNC_BITS-1:0] f, logic [31:0] an, logic [31:0] ad,
                            logic [31:0] bn, logic [DEN_BITS-1:0] bd);
      req_type q;
      q.func  = f;
      q.a_num = an;
      q.a_den = ad;
      q.b_num = bn;
      q.b_den = bd;
      send(q);
   endtask

   initial begin
      req_type q;
      int      p;
      board = new();
      quiet_cycles = 0;
      no_gaps = 1'b0;
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed items: every operation, sign moves, zero and extreme denominators.
      send_item(FN_MAKE, 6, -4, 0, 1);
      send_item(FN_MAKE, 5, 0, 0, 1);
      send_item(FN_MAKE, 32'h8000_0000, 32'h8000_0000, 0, 1);
      send_item(FN_MAKE, 7, 32'h8000_0000, 0, 1);
      send_item(FN_MAKE, 32'h8000_0000, 32'hFFFF_FFFF, 0, 1);
      send_item(FN_ADD, 1, 2, 1, 3);
      send_item(FN_SUB, 1, 6, 1, 4);
      send_item(FN_ADD, 32'h7FFF_FFFF, 1, 1, 1);
      send_item(FN_ADD, 1, 65536, 1, 65536 * 2 + 2);
      send_item(FN_SUB, 3, -7, 2, 0);
      send_item(FN_MUL, 65536, 3, 65536, 5);
      send_item(FN_MUL, 2, 3, 3, 2);
      send_item(FN_DIV, 2, 3, 0, 5);
      send_item(FN_DIV, 32'h8000_0000, 1, -1, 31'h7FFF_FFFF);
      send_item(FN_LT, 1, 3, 1, 2);
      send_item(FN_GT, 32'h7FFF_FFFF, 1, 32'h8000_0000, 1);
      send_item(FN_LE, 2, 4, 1, 2);
      send_item(FN_GE, 1, 32'h8000_0000, 1, 1);
      send_item(FN_LT, -1, 32'h8000_0000, 0, 31'h7FFF_FFFF);
      send_item(FN_SPARE, 1, 2, 3, 4);
      send_item(4'hF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 31'h7FFF_FFFF);

      // Random items, with stretches where no gaps are inserted.
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i % 100 == 0) no_gaps = ($urandom_range(0, 3) == 0);
         p = $urandom_range(0, 99);
         q.func  = (p < 95) ? FUNC_BITS'($urandom_range(0, 8))
                            : FUNC_BITS'($urandom_range(9, 15));
         q.a_num = pick_word();
         q.a_den = pick_word();
         if (q.func != FN_MAKE && $urandom_range(0, 9) < 7 && q.a_den[31])
            q.a_den = -q.a_den;
         q.b_num = pick_word();
         p = $urandom_range(0, 99);
         if (p < 5)       q.b_den = '0;
         else if (p < 15) q.b_den = DEN_BITS'($urandom());
         else             q.b_den = DEN_BITS'(pick_word());
         send(q);
      end
      start <= 1'b0;

      // Wait for every result, then let the block settle.
      while (board.pending.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ----- files.f -----
design/rau_pkg.sv
design/rau_front.sv
design/rau_gcd.sv
design/rau_div.sv
design/rau_back.sv
design/rational_arith_unit.sv
tb/rational_arith_unit_test.sv
